/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the classifier modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while out of reset.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define AST_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/avtc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// avtc_pkg
// Types, constants and helpers of the attribute value type classifier.
// ---------------------------------------------------------------------------
package avtc_pkg;

  localparam int MAX_VALUE_LENGTH = 255;
  localparam int COUNT_LIMIT_INT  = (MAX_VALUE_LENGTH < 255) ? MAX_VALUE_LENGTH : 255;
  localparam logic [7:0] COUNT_LIMIT = 8'(COUNT_LIMIT_INT);

  localparam int NUM_REGS  = 6;
  localparam int IDX_W     = 3;
  localparam int REG_W     = 16;
  localparam logic [REG_W-1:0] BOUNDS_RST = 16'hFF00;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CHARSET = 3'd0;
  localparam logic [IDX_W-1:0] REG_DATE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_LINK    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIME    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SUPER   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ENUM    = 3'd5;

  // bitmap positions
  localparam int B_BOOL    = 0;
  localparam int B_CHARSET = 1;
  localparam int B_DATE    = 2;
  localparam int B_LINK    = 3;
  localparam int B_MIME    = 4;
  localparam int B_SUPER   = 5;
  localparam int B_ENUM    = 6;
  localparam int B_INT     = 7;

  localparam logic [7:0] FLAGS_RST = 8'hFF;

  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [15:0] SUPER_TAIL = {CH_SLASH, CH_STAR};

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // one finished value, handed from front to back
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] flags;
  } avtc_rec_t;

  // (len - lo) mod 256 <= (hi - lo) mod 256
  function automatic logic len_ok(input logic [7:0] len, input logic [REG_W-1:0] bounds);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] d_len;
    logic [7:0] d_rng;
    lo = bounds[7:0];
    hi = bounds[15:8];
    d_len = len - lo;
    d_rng = hi - lo;
    return d_len <= d_rng;
  endfunction

endpackage

/* hdl/avtc_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// avtc_fifo
// Small register queue of finished-value records between front and back.
// ---------------------------------------------------------------------------
module avtc_fifo import avtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  avtc_rec_t push_data,
  output logic      full,
  input  logic      pop,
  output avtc_rec_t pop_data,
  output logic      empty
);
`include "assert_macros.svh"

  avtc_rec_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `AST_CLK(a_no_overflow, !(push && full && !pop), "push into full queue")
  `AST_CLK(a_no_underflow, !(pop && empty), "pop from empty queue")
  `AST_CLK(a_ptr_gap, (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH)) || ((wr_ptr_r - rd_ptr_r) == cnt_r[FIFO_AW-1:0]), "pointer gap disagrees with count")

endmodule

/* hdl/avtc_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// avtc_front
// Per-character class check, candidate flags, length count and tail chars.
// ---------------------------------------------------------------------------
module avtc_front import avtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] value_char,
  input  logic [7:0] name_char,
  input  logic [7:0] name_length,
  input  logic       has_char,
  input  logic       last,
  output logic       push,
  output avtc_rec_t  push_data
);
`include "assert_macros.svh"

  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] prev_r, prev_nxt;

  logic [7:0]  cnt_upd, flags_upd, keep, fin;
  logic [15:0] prev_upd;
  logic digit, alpha, minus, plus, dot, colon, uscore, slash;

  always_comb begin
    digit  = (value_char >= 8'h30) && (value_char <= 8'h39);
    alpha  = ((value_char >= 8'h41) && (value_char <= 8'h5A)) ||
             ((value_char >= 8'h61) && (value_char <= 8'h7A));
    minus  = (value_char == CH_MINUS);
    plus   = (value_char == CH_PLUS);
    dot    = (value_char == CH_DOT);
    colon  = (value_char == CH_COLON);
    uscore = (value_char == CH_USCORE);
    slash  = (value_char == CH_SLASH);

    keep            = '0;
    keep[B_BOOL]    = alpha && (value_char == name_char) && (cnt_r < name_length);
    keep[B_CHARSET] = alpha || digit || minus || uscore || dot || colon;
    keep[B_DATE]    = digit || plus || minus || (value_char == CH_SPACE) || dot || colon ||
                      (value_char == CH_T) || (value_char == CH_Z) || (value_char == CH_W);
    keep[B_LINK]    = alpha || minus;
    keep[B_MIME]    = alpha || digit || plus || minus || slash || dot;
    keep[B_SUPER]   = alpha || slash || (value_char == CH_STAR);
    keep[B_ENUM]    = alpha || digit || minus || uscore;
    keep[B_INT]     = digit || ((cnt_r == '0) && (plus || minus));

    if (has_char) begin
      flags_upd = flags_r & keep;
      prev_upd  = {prev_r[7:0], value_char};
      cnt_upd   = (cnt_r < COUNT_LIMIT) ? cnt_r + 1'b1 : cnt_r;
    end else begin
      flags_upd = flags_r;
      prev_upd  = prev_r;
      cnt_upd   = cnt_r;
    end

    // end checks on the final length and the last two chars
    fin = flags_upd;
    if (cnt_upd != name_length) begin
      fin[B_BOOL] = 1'b0;
    end
    if ((cnt_upd < 8'd2) || (prev_upd != SUPER_TAIL)) begin
      fin[B_SUPER] = 1'b0;
    end

    push            = acc && last;
    push_data.len   = cnt_upd;
    push_data.flags = fin;

    cnt_nxt   = cnt_r;
    flags_nxt = flags_r;
    prev_nxt  = prev_r;
    if (acc) begin
      if (last) begin
        cnt_nxt   = '0;
        flags_nxt = FLAGS_RST;
        prev_nxt  = '0;
      end else begin
        cnt_nxt   = cnt_upd;
        flags_nxt = flags_upd;
        prev_nxt  = prev_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      flags_r <= FLAGS_RST;
      prev_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      flags_r <= flags_nxt;
      prev_r  <= prev_nxt;
    end
  end

  `AST_CLK(a_clear_after_last, push |=> (cnt_r == '0) && (flags_r == FLAGS_RST), "state not cleared after last")
  `AST_CLK(a_count_limit, cnt_r <= COUNT_LIMIT, "length count past limit")

endmodule

/* hdl/avtc_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// avtc_back
// Length-bound registers, bound qualification, type exclusion, result reg.
// ---------------------------------------------------------------------------
module avtc_back import avtc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0] cfg_wdata,
  input  logic             empty,
  input  avtc_rec_t        rec,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata
);
`include "assert_macros.svh"

  logic [REG_W-1:0] bnd_r [NUM_REGS];
  logic             vld_r, vld_nxt;
  logic [7:0]       res_r;
  logic [7:0]       f, res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        bnd_r[i] <= BOUNDS_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CHARSET: bnd_r[REG_CHARSET] <= cfg_wdata;
        REG_DATE:    bnd_r[REG_DATE]    <= cfg_wdata;
        REG_LINK:    bnd_r[REG_LINK]    <= cfg_wdata;
        REG_MIME:    bnd_r[REG_MIME]    <= cfg_wdata;
        REG_SUPER:   bnd_r[REG_SUPER]   <= cfg_wdata;
        REG_ENUM:    bnd_r[REG_ENUM]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    f = rec.flags;
    if (!len_ok(rec.len, bnd_r[REG_CHARSET])) f[B_CHARSET] = 1'b0;
    if (!len_ok(rec.len, bnd_r[REG_DATE]))    f[B_DATE]    = 1'b0;
    if (!len_ok(rec.len, bnd_r[REG_LINK]))    f[B_LINK]    = 1'b0;
    if (!len_ok(rec.len, bnd_r[REG_MIME]))    f[B_MIME]    = 1'b0;
    if (!len_ok(rec.len, bnd_r[REG_SUPER]))   f[B_SUPER]   = 1'b0;
    if (!len_ok(rec.len, bnd_r[REG_ENUM]))    f[B_ENUM]    = 1'b0;

    if (f[B_BOOL]) begin
      res = 8'(1) << B_BOOL;
    end else if (f[B_INT]) begin
      res = 8'(1) << B_INT;
    end else begin
      res = f;
    end

    pop     = !empty && (!vld_r || out_tready);
    vld_nxt = pop ? 1'b1 : (out_tready ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = res_r;

  `AST_CLK(a_pop_fills, pop |=> vld_r, "popped record not presented")
  `AST_CLK(a_excl, !vld_r || !res_r[B_BOOL] || (res_r == (8'(1) << B_BOOL)), "boolean not exclusive")

endmodule

/* hdl/attribute_value_type_classifier_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// attribute_value_type_classifier_unit
// Classifies an attribute value, one character per transfer, into a bitmap of
// possible value types. Takes one input transfer every cycle while the queue is not
// full; the bitmap of a value enters the queue with the transfer marked tlast and
// is then registered in the result stage. A four-entry queue of finished values
// sits between the character front end and the result stage, so the input stalls
// only when four results wait behind a stalled output. Length bounds are to be
// written through the cfg port only while no value is in flight (unenforced).
// ---------------------------------------------------------------------------
module attribute_value_type_classifier_unit import avtc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // value_char[7:0], name_char[15:8], name_length[23:16]
  input  logic             in_tuser,   // has_char
  input  logic             in_tlast,   // last
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // type_bitmap[7:0]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  logic      full, empty, push, pop, acc;
  avtc_rec_t push_data, pop_data;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  avtc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .value_char  (in_tdata[7:0]),
    .name_char   (in_tdata[15:8]),
    .name_length (in_tdata[23:16]),
    .has_char    (in_tuser),
    .last        (in_tlast),
    .push        (push),
    .push_data   (push_data)
  );

  avtc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  avtc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .empty      (empty),
    .rec        (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
